### hw/rtl/lchs_pkg.sv
// Shared types, constants and helper functions for the LED color HSV/SPI encoder.
// No dependencies; imported by every module of the block.
package lchs_pkg;

	// color queue between front and back
	localparam int QDepth = 8;
	localparam int QAw    = $clog2(QDepth);
	localparam int QCw    = $clog2(QDepth + 1);

	// configuration register indexes
	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_ZERO_PATTERN = 2'd0;
	localparam reg_idx_t REG_ONE_PATTERN  = 2'd1;
	localparam reg_idx_t REG_RESET_WORDS  = 2'd2;

	// register reset values
	localparam logic [7:0] ZERO_PATTERN_RST = 8'b0000_0011;
	localparam logic [7:0] ONE_PATTERN_RST  = 8'b0001_1111;
	localparam logic [3:0] RESET_WORDS_RST  = 4'd9;
	localparam logic [3:0] MAX_RESET_WORDS  = 4'd9;

	// HSV constants
	localparam logic [8:0]  HUE_MAX     = 9'd359;
	localparam logic [5:0]  SECTOR_DEG  = 6'd60;
	// floor(x/60) = (x * RECIP_60) >> RECIP_SHIFT, exact for x below 23879
	localparam logic [14:0] RECIP_60    = 15'd17477;
	localparam int          RECIP_SHIFT = 20;

	// output channel codes
	typedef enum logic [1:0] {
		CH_RESET = 2'd0,
		CH_GREEN = 2'd1,
		CH_RED   = 2'd2,
		CH_BLUE  = 2'd3
	} chan_t;

	// one converted LED color
	typedef struct packed {
		logic       frame_start;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} color_t;

	// queue status seen by front and back
	typedef struct packed {
		logic           empty;
		logic [QCw-1:0] count;
	} qstat_t;

	// configuration register set
	typedef struct packed {
		logic [7:0] zero_pattern;
		logic [7:0] one_pattern;
		logic [3:0] reset_words;
	} cfg_t;

	// expand one channel level into eight symbol bytes, data bit 7 in the top byte
	function automatic logic [63:0] expand_channel(input logic [7:0] level,
		input logic [7:0] zero_pat, input logic [7:0] one_pat);
		logic [63:0] word;
		word = '0;
		for (int i = 0; i < 8; i++) begin
			word[8*i +: 8] = level[i] ? one_pat : zero_pat;
		end
		return word;
	endfunction

endpackage

### hw/rtl/lchs_front.sv
// Front part: accepts input items, converts HSV to RGB or passes RGB through, in a four-stage pipeline.
// Depends on lchs_pkg; pushes finished colors into lchs_queue.
module lchs_front
	import lchs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // red[7:0], green[15:8], blue[23:16], hue[32:24],
	                               // saturation[40:33], brightness[48:41], zero fill
	input  logic [1:0]  s_tuser,   // command[0], frame_start[1]
	input  qstat_t      qstat,
	output logic        push,
	output color_t      push_data
);

	// input field split
	logic [7:0] in_red, in_green, in_blue, in_sat, in_bri;
	logic [8:0] in_hue;
	assign in_red   = s_tdata[7:0];
	assign in_green = s_tdata[15:8];
	assign in_blue  = s_tdata[23:16];
	assign in_hue   = s_tdata[32:24];
	assign in_sat   = s_tdata[40:33];
	assign in_bri   = s_tdata[48:41];

	logic v_s1, v_s2, v_s3, v_s4;
	logic accept;

	// credit check: queue entries plus items in flight never exceed the depth
	logic [QCw:0] used;
	assign used     = {1'b0, qstat.count} + (QCw + 1)'($countones({v_s1, v_s2, v_s3, v_s4}));
	assign s_tready = (used < (QCw + 1)'(QDepth));
	assign accept   = s_tvalid && s_tready;

	// hue clamp and sector search
	logic [8:0] hue_c, base_c;
	logic [2:0] sector_c;
	logic [5:0] frac_c;
	always_comb begin
		hue_c = (in_hue > HUE_MAX) ? HUE_MAX : in_hue;
		if (hue_c >= 9'd300) begin
			sector_c = 3'd5; base_c = 9'd300;
		end else if (hue_c >= 9'd240) begin
			sector_c = 3'd4; base_c = 9'd240;
		end else if (hue_c >= 9'd180) begin
			sector_c = 3'd3; base_c = 9'd180;
		end else if (hue_c >= 9'd120) begin
			sector_c = 3'd2; base_c = 9'd120;
		end else if (hue_c >= 9'd60) begin
			sector_c = 3'd1; base_c = 9'd60;
		end else begin
			sector_c = 3'd0; base_c = 9'd0;
		end
		frac_c = 6'(hue_c - base_c);
	end

	// stage payloads
	logic       cmd_s1, cmd_s2, cmd_s3, cmd_s4;
	logic       gray_s1, gray_s2, gray_s3, gray_s4;
	logic [2:0] sector_s1, sector_s2, sector_s3, sector_s4;
	logic [5:0] frac_s1;
	logic [7:0] sat_s1;
	logic [7:0] bri_s1, bri_s2, bri_s3, bri_s4;
	color_t     rgb_s1, rgb_s2, rgb_s3, rgb_s4;
	logic [13:0] sf_s2, sg_s2;
	logic [7:0] p_s2, p_s3, p_s4;
	logic [7:0] qd_s3, td_s3;
	logic [7:0] q_s4, t_s4;

	// stage 2 products: S*F, S*(60-F), V*(255-S)
	logic [13:0] sf_c, sg_c;
	logic [15:0] p_prod;
	assign sf_c   = {6'd0, sat_s1} * {8'd0, frac_s1};
	assign sg_c   = {6'd0, sat_s1} * {8'd0, SECTOR_DEG - frac_s1};
	assign p_prod = {8'd0, bri_s1} * {8'd0, 8'd255 - sat_s1};

	// stage 3: divide by 60 through the reciprocal
	logic [28:0] qd_prod, td_prod;
	assign qd_prod = {15'd0, sf_s2} * {14'd0, RECIP_60};
	assign td_prod = {15'd0, sg_s2} * {14'd0, RECIP_60};

	// stage 4: scale by brightness / 256
	logic [15:0] q_prod, t_prod;
	assign q_prod = {8'd0, bri_s3} * {8'd0, 8'd255 - qd_s3};
	assign t_prod = {8'd0, bri_s3} * {8'd0, 8'd255 - td_s3};

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage payload registers
	always_ff @(posedge clk) begin
		cmd_s1    <= s_tuser[0];
		gray_s1   <= (in_sat == 8'd0);
		sector_s1 <= sector_c;
		frac_s1   <= frac_c;
		sat_s1    <= in_sat;
		bri_s1    <= in_bri;
		rgb_s1    <= '{frame_start: s_tuser[1], red: in_red, green: in_green, blue: in_blue};

		cmd_s2    <= cmd_s1;
		gray_s2   <= gray_s1;
		sector_s2 <= sector_s1;
		bri_s2    <= bri_s1;
		rgb_s2    <= rgb_s1;
		sf_s2     <= sf_c;
		sg_s2     <= sg_c;
		p_s2      <= p_prod[15:8];

		cmd_s3    <= cmd_s2;
		gray_s3   <= gray_s2;
		sector_s3 <= sector_s2;
		bri_s3    <= bri_s2;
		rgb_s3    <= rgb_s2;
		p_s3      <= p_s2;
		qd_s3     <= qd_prod[RECIP_SHIFT +: 8];
		td_s3     <= td_prod[RECIP_SHIFT +: 8];

		cmd_s4    <= cmd_s3;
		gray_s4   <= gray_s3;
		sector_s4 <= sector_s3;
		bri_s4    <= bri_s3;
		rgb_s4    <= rgb_s3;
		p_s4      <= p_s3;
		q_s4      <= q_prod[15:8];
		t_s4      <= t_prod[15:8];
	end

	// sector selection, gray and RGB passthrough
	always_comb begin
		push_data.frame_start = rgb_s4.frame_start;
		if (!cmd_s4) begin
			push_data.red   = rgb_s4.red;
			push_data.green = rgb_s4.green;
			push_data.blue  = rgb_s4.blue;
		end else if (gray_s4) begin
			push_data.red   = bri_s4;
			push_data.green = bri_s4;
			push_data.blue  = bri_s4;
		end else begin
			case (sector_s4)
				3'd0: begin
					push_data.red = bri_s4; push_data.green = t_s4; push_data.blue = p_s4;
				end
				3'd1: begin
					push_data.red = q_s4; push_data.green = bri_s4; push_data.blue = p_s4;
				end
				3'd2: begin
					push_data.red = p_s4; push_data.green = bri_s4; push_data.blue = t_s4;
				end
				3'd3: begin
					push_data.red = p_s4; push_data.green = q_s4; push_data.blue = bri_s4;
				end
				3'd4: begin
					push_data.red = t_s4; push_data.green = p_s4; push_data.blue = bri_s4;
				end
				default: begin
					push_data.red = bri_s4; push_data.green = p_s4; push_data.blue = q_s4;
				end
			endcase
		end
	end

	assign push = v_s4;

endmodule

### hw/rtl/lchs_queue.sv
// Color queue between the conversion front and the word sequencer.
// Depends on lchs_pkg for depth, color_t and qstat_t.
module lchs_queue
	import lchs_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  color_t push_data,
	input  logic   pop,
	output color_t head,
	output qstat_t qstat
);

	color_t         mem_q [QDepth];
	logic [QAw-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCw-1:0] count_q;

	// storage write
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= QAw'(wr_ptr_q + 1'b1);
			if (pop)  rd_ptr_q <= QAw'(rd_ptr_q + 1'b1);
			case ({push, pop})
				2'b10:   count_q <= QCw'(count_q + 1'b1);
				2'b01:   count_q <= QCw'(count_q - 1'b1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign head        = mem_q[rd_ptr_q];
	assign qstat.count = count_q;
	assign qstat.empty = (count_q == '0);

endmodule

### hw/rtl/lchs_back.sv
// Back part: emits reset words and the green, red, blue symbol words per color.
// Depends on lchs_pkg; pops colors from lchs_queue, drives the output register.
module lchs_back
	import lchs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  qstat_t      qstat,
	input  color_t      head,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // symbol_word[63:0]
	output logic [1:0]  m_tuser,   // channel[1:0]
	output logic        m_tlast
);

	logic        m_tvalid_q, m_tlast_q;
	logic [63:0] m_tdata_q;
	chan_t       m_chan_q;
	chan_t       ch_q;
	logic        started_q;
	logic [3:0]  rst_left_q;

	logic       load, go, emit_reset;
	logic [3:0] init_cnt, rem;
	logic [7:0] level;

	// output slot free and a color waiting
	assign load = !m_tvalid_q || m_tready;
	assign go   = load && !qstat.empty;

	// reset words left for the head color
	always_comb begin
		if (head.frame_start) begin
			init_cnt = (cfg.reset_words > MAX_RESET_WORDS) ? MAX_RESET_WORDS : cfg.reset_words;
		end else begin
			init_cnt = 4'd0;
		end
		rem        = started_q ? rst_left_q : init_cnt;
		emit_reset = (rem != 4'd0);
	end

	// channel level for the current word
	always_comb begin
		case (ch_q)
			CH_GREEN: level = head.green;
			CH_RED:   level = head.red;
			default:  level = head.blue;
		endcase
	end

	assign pop = go && !emit_reset && (ch_q == CH_BLUE);

	// sequencer state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			ch_q       <= CH_GREEN;
			started_q  <= 1'b0;
			rst_left_q <= 4'd0;
		end else begin
			if (load) m_tvalid_q <= go;
			if (go) begin
				if (emit_reset) begin
					rst_left_q <= rem - 4'd1;
					started_q  <= 1'b1;
				end else if (ch_q == CH_BLUE) begin
					ch_q       <= CH_GREEN;
					started_q  <= 1'b0;
					rst_left_q <= 4'd0;
				end else begin
					ch_q       <= chan_t'(ch_q + 2'd1);
					started_q  <= 1'b1;
					rst_left_q <= 4'd0;
				end
			end
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (go) begin
			if (emit_reset) begin
				m_tdata_q <= '0;
				m_chan_q  <= CH_RESET;
				m_tlast_q <= 1'b0;
			end else begin
				m_tdata_q <= expand_channel(level, cfg.zero_pattern, cfg.one_pattern);
				m_chan_q  <= ch_q;
				m_tlast_q <= (ch_q == CH_BLUE);
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_chan_q;
	assign m_tlast  = m_tlast_q;

endmodule

### hw/rtl/led_color_hsv_spi_encoder_core.sv
// LED color encoder top level: config registers, front, queue and back.
// Path from an accepted item to its first word: 4 conversion stages, queue, output reg.
// Each item yields 3 + R words, R = reset words for a frame start; the back sequencer
//   emits one 64-bit word per cycle while a color waits and the output is not stalled. The front
//   takes one item per cycle until the 8-entry queue and the pipeline hold 8 items.
// Reset: arst_n clears all control state and loads the register reset values; no clearing pass.
module led_color_hsv_spi_encoder_core
	import lchs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [7:0]  cfg_wdata,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // red[7:0], green[15:8], blue[23:16], hue[32:24],
	                               // saturation[40:33], brightness[48:41], zero fill
	input  logic [1:0]  s_tuser,   // command[0], frame_start[1]
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // symbol_word[63:0]
	output logic [1:0]  m_tuser,   // channel[1:0]
	output logic        m_tlast
);

	cfg_t   cfg_q;
	qstat_t qstat;
	color_t push_data, head;
	logic   push, pop;

	// configuration registers; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.zero_pattern <= ZERO_PATTERN_RST;
			cfg_q.one_pattern  <= ONE_PATTERN_RST;
			cfg_q.reset_words  <= RESET_WORDS_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_ZERO_PATTERN: cfg_q.zero_pattern <= cfg_wdata;
				REG_ONE_PATTERN:  cfg_q.one_pattern  <= cfg_wdata;
				REG_RESET_WORDS:  cfg_q.reset_words  <= cfg_wdata[3:0];
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	lchs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	lchs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	lchs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.qstat    (qstat),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// queue never overfills and never pops empty
	assert property (@(posedge clk) disable iff (!arst_n)
		(qstat.count <= QCw'(QDepth)) && !(pop && qstat.empty))
		else $error("color queue over- or underflow");

	// a push into a full queue would lose a color
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (qstat.count < QCw'(QDepth)) || pop)
		else $error("push into full color queue");

	// last word of an LED is always the blue channel
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser == CH_BLUE)
		else $error("last flag on a non-blue word");

	// reset words carry all-zero symbols
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == CH_RESET) |-> (m_tdata == 64'd0) && !m_tlast)
		else $error("reset word with nonzero payload");

endmodule
